/* hdl/sas_pkg.sv */
// shared types and constants for the shifting array store
package sas_pkg;

	localparam int WORD_W    = 32;
	localparam int OP_W      = 3;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int POS_W     = 9;
	localparam int DEPTH_DEF = 16;
	localparam int IDX_SPAN  = 1 << IDX_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_SET    = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_SET,
		CMD_REMOVE,
		CMD_ROTATE
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_COUNT
	} state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] value;
	} cell_ctl_t;

endpackage

/* hdl/sas_cell.sv */
// one storage cell of the shifting chain
module sas_cell #(
	parameter int POS   = 0,
	parameter int DEPTH = sas_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sas_pkg::cell_ctl_t         ctl,
	input  logic [sas_pkg::WORD_W-1:0] left_word,
	input  logic [sas_pkg::WORD_W-1:0] right_word,
	output logic [sas_pkg::WORD_W-1:0] word
);
	import sas_pkg::*;

	localparam logic [POS_W-1:0] POS_V   = POS_W'(POS);
	localparam bit               IS_LAST = (POS == DEPTH - 1);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_nx;
	logic [POS_W-1:0]  idx_ext;
	logic              pos_gt;
	logic              pos_eq;

	assign idx_ext = POS_W'(ctl.idx);
	assign pos_gt  = POS_V > idx_ext;
	assign pos_eq  = POS_V == idx_ext;

	always_comb begin
		unique case (ctl.cmd)
			CMD_HOLD:   word_nx = word_q;
			CMD_INSERT: word_nx = pos_gt ? left_word : (pos_eq ? ctl.value : word_q);
			CMD_SET:    word_nx = pos_eq ? ctl.value : word_q;
			CMD_REMOVE: begin
				if (pos_gt || pos_eq) begin
					word_nx = IS_LAST ? '0 : right_word;
				end else begin
					word_nx = word_q;
				end
			end
			CMD_ROTATE: word_nx = right_word;
			default:    word_nx = word_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q <= word_nx;
		end
	end

	assign word = word_q;

endmodule

/* hdl/sas_ctrl.sv */
// operation decode, count sequencer and result register
module sas_ctrl #(
	parameter int DEPTH = sas_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sas_pkg::OP_W-1:0]   op,
	input  logic [sas_pkg::IDX_W-1:0]  index,
	input  logic [sas_pkg::WORD_W-1:0] value,
	input  logic [sas_pkg::WORD_W-1:0] rd_word,
	input  logic [sas_pkg::WORD_W-1:0] head_word,
	output sas_pkg::cell_ctl_t         ctl,
	output logic                       busy,
	output logic                       done,
	output logic [sas_pkg::WORD_W-1:0] rd_value,
	output logic [sas_pkg::CNT_W-1:0]  count
);
	import sas_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam logic [SW-1:0] LAST_STEP = SW'(DEPTH - 1);

	state_t            state_q;
	state_t            state_nx;
	logic [SW-1:0]     step_q;
	logic [SW-1:0]     step_nx;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_nx;
	logic [WORD_W-1:0] val_q;
	logic [WORD_W-1:0] val_nx;
	logic              done_q;
	logic              done_nx;
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] rd_nx;
	logic [CNT_W-1:0]  mc_q;
	logic [CNT_W-1:0]  mc_nx;
	logic              in_range;
	logic              hit;
	logic [CNT_W-1:0]  cnt_inc;

	assign in_range = int'(index) < DEPTH;
	assign hit      = head_word == val_q;
	assign cnt_inc  = (hit && cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		state_nx  = state_q;
		step_nx   = step_q;
		cnt_nx    = cnt_q;
		val_nx    = val_q;
		done_nx   = 1'b0;
		rd_nx     = rd_q;
		mc_nx     = mc_q;
		busy      = 1'b0;
		ctl.cmd   = CMD_HOLD;
		ctl.idx   = index;
		ctl.value = value;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (op)
						OP_INSERT: ctl.cmd = in_range ? CMD_INSERT : CMD_HOLD;
						OP_SET:    ctl.cmd = in_range ? CMD_SET : CMD_HOLD;
						OP_REMOVE: ctl.cmd = in_range ? CMD_REMOVE : CMD_HOLD;
						default:   ctl.cmd = CMD_HOLD;
					endcase
					if (op == OP_COUNT) begin
						state_nx = ST_COUNT;
						step_nx  = '0;
						cnt_nx   = '0;
						val_nx   = value;
					end else begin
						done_nx = 1'b1;
						rd_nx   = (op == OP_READ) ? rd_word : '0;
						mc_nx   = '0;
					end
				end
			end
			ST_COUNT: begin
				// rotate the chain once per cycle, compare at the head
				busy    = 1'b1;
				ctl.cmd = CMD_ROTATE;
				cnt_nx  = cnt_inc;
				step_nx = step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					state_nx = ST_IDLE;
					done_nx  = 1'b1;
					rd_nx    = '0;
					mc_nx    = cnt_inc;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			step_q  <= step_nx;
			cnt_q   <= cnt_nx;
			done_q  <= done_nx;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nx;
		rd_q  <= rd_nx;
		mc_q  <= mc_nx;
	end

	assign done     = done_q;
	assign rd_value = rd_q;
	assign count    = mc_q;

endmodule

/* hdl/shifting_array_store_top.sv */
// top level of the shifting array store: a chain of word cells plus control
// read, insert, set, remove: done the cycle after acceptance, one per cycle while idle
// count: busy while the chain rotates once past the head comparator,
//   then done with the count, which is registered as the rotation ends
// results cannot be stalled; done is high for exactly one cycle per item
// arst_n clears every cell to zero and returns control to idle immediately
module shifting_array_store_top #(
	parameter int DEPTH = sas_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [sas_pkg::OP_W-1:0]          op,
	input  logic [sas_pkg::IDX_W-1:0]         index,
	input  logic signed [sas_pkg::WORD_W-1:0] value,
	output logic                              done,
	output logic signed [sas_pkg::WORD_W-1:0] read_value,
	output logic [sas_pkg::CNT_W-1:0]         match_count
);
	import sas_pkg::*;

	// cell words, cell 0 is the head of the chain
	logic [WORD_W-1:0] word [DEPTH];
	// index-wide view of the chain for reads, zero past the top entry
	logic [WORD_W-1:0] rd_view [IDX_SPAN];
	cell_ctl_t         ctl;
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] rd_value;

	sas_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (op),
		.index    (index),
		.value    (value),
		.rd_word  (rd_word),
		.head_word(word[0]),
		.ctl      (ctl),
		.busy     (busy),
		.done     (done),
		.rd_value (rd_value),
		.count    (match_count)
	);

	// chain of cells: each sees its lower and upper neighbor,
	// the top cell's upper neighbor wraps to the head for the count rotation
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_body
			assign left_w = word[i-1];
		end
		if (i == DEPTH - 1) begin : g_wrap
			assign right_w = word[0];
		end else begin : g_next
			assign right_w = word[i+1];
		end
		sas_cell #(
			.POS  (i),
			.DEPTH(DEPTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left_word (left_w),
			.right_word(right_w),
			.word      (word[i])
		);
	end

	// read mux covers only the positions an index can reach
	for (genvar j = 0; j < IDX_SPAN; j++) begin : g_view
		if (j < DEPTH) begin : g_live
			assign rd_view[j] = word[j];
		end else begin : g_pad
			assign rd_view[j] = '0;
		end
	end

	assign rd_word    = rd_view[index];
	assign read_value = rd_value;

	// a non-count item always finishes in the next cycle
	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op != OP_COUNT) |=> done)
		else $error("non-count item did not finish in one cycle");

	// a count item holds off new items while the chain rotates
	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_COUNT) |=> (busy && !done))
		else $error("count item did not enter the rotation");

	// a nonzero count never comes with read data
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && match_count != '0) |-> (read_value == '0))
		else $error("count and read data both nonzero");

	// a count can never exceed the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(match_count) <= DEPTH))
		else $error("match count exceeds depth");

endmodule
